// ===== src/bpms_pkg.sv =====
// Shared types, register indexes and reset values for the battery power mode sequencer.
package bpms_pkg;

   localparam int TIME_BITS_DEFAULT = 32;
   localparam int NOW_W = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 20;

   typedef enum logic [1:0] {
      MODE_AC          = 2'd0,
      MODE_BATT_ACTIVE = 2'd1,
      MODE_BATT_SLEEP  = 2'd2,
      MODE_CONNECTING  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ACT_TICK   = 2'd0,
      ACT_SOURCE = 2'd1,
      ACT_CHECK  = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DEBOUNCE     = 3'd0,
      CSR_SLEEP        = 3'd1,
      CSR_AWAKE        = 3'd2,
      CSR_CRITICAL     = 3'd3,
      CSR_TRY_WINDOW   = 3'd4,
      CSR_WAIT_END     = 3'd5,
      CSR_CHECK_PERIOD = 3'd6,
      CSR_MAX_ATTEMPTS = 3'd7
   } csr_index_type;

   localparam logic [15:0] DEBOUNCE_RST     = 16'd3000;
   localparam logic [19:0] SLEEP_RST        = 20'd60000;
   localparam logic [19:0] AWAKE_RST        = 20'd10000;
   localparam logic [6:0]  CRITICAL_RST     = 7'd10;
   localparam logic [19:0] TRY_WINDOW_RST   = 20'd10000;
   localparam logic [19:0] WAIT_END_RST     = 20'd40000;
   localparam logic [15:0] CHECK_PERIOD_RST = 16'd5000;
   localparam logic [3:0]  MAX_ATTEMPTS_RST = 4'd3;

   typedef struct packed {
      logic [15:0] debounce_ms;
      logic [19:0] sleep_ms;
      logic [19:0] awake_ms;
      logic [6:0]  critical_level;
      logic [19:0] try_window_ms;
      logic [19:0] wait_end_ms;
      logic [15:0] check_period_ms;
      logic [3:0]  max_attempts;
   } cfg_type;

   typedef struct packed {
      logic [1:0]       action;
      logic [NOW_W-1:0] now_ms;
      logic             on_battery_now;
      logic             wifi_connected;
      logic             client_present;
      logic [6:0]       battery_level;
   } req_type;

   typedef struct packed {
      logic [1:0] power_mode;
      logic [1:0] prior_mode;
      logic       radio_sleep;
      logic       cpu_fast;
      logic       pm_owns_link;
      logic       led_clear;
      logic       link_begin;
      logic       critical_override;
      logic       mode_changed;
      logic       change_ignored;
   } rsp_type;

endpackage

// ===== src/battery_power_mode_sequencer.sv =====
// Battery power mode sequencer: input register, mode logic and result register.
// A transaction accepted into the input register moves into the result register
// once that register is empty or being emptied, and rsp_valid then rises.
// Throughput: one transaction per cycle while the consumer takes results; the single
// pass through the mode logic between the input and result registers sets that figure.
// Reset (synchronous, active high) returns the mode state and registers to
// their defaults and empties both pipeline registers.
module battery_power_mode_sequencer #(
   parameter int TIME_BITS = bpms_pkg::TIME_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_action,
   input  logic [bpms_pkg::NOW_W-1:0]       req_now_ms,
   input  logic                             req_on_battery_now,
   input  logic                             req_wifi_connected,
   input  logic                             req_client_present,
   input  logic [6:0]                       req_battery_level,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [1:0]                       rsp_power_mode,
   output logic [1:0]                       rsp_prior_mode,
   output logic                             rsp_radio_sleep,
   output logic                             rsp_cpu_fast,
   output logic                             rsp_pm_owns_link,
   output logic                             rsp_led_clear,
   output logic                             rsp_link_begin,
   output logic                             rsp_critical_override,
   output logic                             rsp_mode_changed,
   output logic                             rsp_change_ignored,
   input  logic                             csr_write,
   input  logic [bpms_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bpms_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   logic              in_valid_ff;
   bpms_pkg::req_type in_item_ff;
   logic              rsp_valid_ff;
   bpms_pkg::rsp_type rsp_item_ff;
   logic              advance;
   bpms_pkg::cfg_type cfg;
   bpms_pkg::rsp_type result;

   // The held transaction moves into the result register whenever that
   // register is empty or is being emptied in this cycle.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= (req_valid && req_ready) || (in_valid_ff && !advance);
         rsp_valid_ff <= advance || (rsp_valid_ff && !rsp_ready);
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff.action         <= req_action;
         in_item_ff.now_ms         <= req_now_ms;
         in_item_ff.on_battery_now <= req_on_battery_now;
         in_item_ff.wifi_connected <= req_wifi_connected;
         in_item_ff.client_present <= req_client_present;
         in_item_ff.battery_level  <= req_battery_level;
      end
      if (advance) begin
         rsp_item_ff <= result;
      end
   end

   bpms_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bpms_core #(
      .TIME_BITS (TIME_BITS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_item_ff),
      .cfg     (cfg),
      .result  (result)
   );

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_power_mode        = rsp_item_ff.power_mode;
   assign rsp_prior_mode        = rsp_item_ff.prior_mode;
   assign rsp_radio_sleep       = rsp_item_ff.radio_sleep;
   assign rsp_cpu_fast          = rsp_item_ff.cpu_fast;
   assign rsp_pm_owns_link      = rsp_item_ff.pm_owns_link;
   assign rsp_led_clear         = rsp_item_ff.led_clear;
   assign rsp_link_begin        = rsp_item_ff.link_begin;
   assign rsp_critical_override = rsp_item_ff.critical_override;
   assign rsp_mode_changed      = rsp_item_ff.mode_changed;
   assign rsp_change_ignored    = rsp_item_ff.change_ignored;

endmodule

// ===== src/bpms_cfg.sv =====
// Configuration register bank with its write decode.
module bpms_cfg (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write,
   input  logic [bpms_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [bpms_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output bpms_pkg::cfg_type                   cfg
);

   bpms_pkg::cfg_type cfg_ff;
   bpms_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (bpms_pkg::csr_index_type'(csr_index))
            bpms_pkg::CSR_DEBOUNCE:     cfg_in.debounce_ms     = csr_wdata[15:0];
            bpms_pkg::CSR_SLEEP:        cfg_in.sleep_ms        = csr_wdata;
            bpms_pkg::CSR_AWAKE:        cfg_in.awake_ms        = csr_wdata;
            bpms_pkg::CSR_CRITICAL:     cfg_in.critical_level  = csr_wdata[6:0];
            bpms_pkg::CSR_TRY_WINDOW:   cfg_in.try_window_ms   = csr_wdata;
            bpms_pkg::CSR_WAIT_END:     cfg_in.wait_end_ms     = csr_wdata;
            bpms_pkg::CSR_CHECK_PERIOD: cfg_in.check_period_ms = csr_wdata[15:0];
            bpms_pkg::CSR_MAX_ATTEMPTS: cfg_in.max_attempts    = csr_wdata[3:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms     <= bpms_pkg::DEBOUNCE_RST;
         cfg_ff.sleep_ms        <= bpms_pkg::SLEEP_RST;
         cfg_ff.awake_ms        <= bpms_pkg::AWAKE_RST;
         cfg_ff.critical_level  <= bpms_pkg::CRITICAL_RST;
         cfg_ff.try_window_ms   <= bpms_pkg::TRY_WINDOW_RST;
         cfg_ff.wait_end_ms     <= bpms_pkg::WAIT_END_RST;
         cfg_ff.check_period_ms <= bpms_pkg::CHECK_PERIOD_RST;
         cfg_ff.max_attempts    <= bpms_pkg::MAX_ATTEMPTS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== src/bpms_core.sv =====
// Mode state registers and the single-pass next-state and result logic.
module bpms_core #(
   parameter int TIME_BITS = bpms_pkg::TIME_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  bpms_pkg::req_type item,
   input  bpms_pkg::cfg_type cfg,
   output bpms_pkg::rsp_type result
);

   // Compares run at a width that holds both the elapsed time and the
   // sleep plus awake sum.
   localparam int CMP_W = (TIME_BITS > 21) ? TIME_BITS : 21;

   bpms_pkg::mode_type     mode_ff, mode_in;
   bpms_pkg::mode_type     prev_mode_ff, prev_mode_in;
   logic [TIME_BITS-1:0]   entered_at_ff, entered_at_in;
   logic [TIME_BITS-1:0]   last_source_ff, last_source_in;
   logic                   battery_flag_ff, battery_flag_in;
   logic [TIME_BITS-1:0]   cycle_start_ff, cycle_start_in;
   logic [3:0]             connect_tries_ff, connect_tries_in;
   logic [3:0]             wake_tries_ff, wake_tries_in;
   logic                   client_flag_ff, client_flag_in;
   logic [TIME_BITS-1:0]   last_check_ff, last_check_in;
   logic                   radio_sleep_ff, radio_sleep_in;
   logic                   cpu_fast_ff, cpu_fast_in;
   logic                   owns_link_ff, owns_link_in;

   logic [TIME_BITS-1:0]   now_t;
   logic [CMP_W-1:0]       el_cycle, el_entered, el_source, el_check;
   logic [CMP_W-1:0]       sleep_end;
   logic                   do_enter;
   bpms_pkg::mode_type     target;
   logic                   p_led, p_link, p_crit, p_changed, p_ignored;

   assign now_t      = TIME_BITS'(item.now_ms);
   assign el_cycle   = CMP_W'(TIME_BITS'(now_t - cycle_start_ff));
   assign el_entered = CMP_W'(TIME_BITS'(now_t - entered_at_ff));
   assign el_source  = CMP_W'(TIME_BITS'(now_t - last_source_ff));
   assign el_check   = CMP_W'(TIME_BITS'(now_t - last_check_ff));
   assign sleep_end  = CMP_W'(cfg.sleep_ms) + CMP_W'(cfg.awake_ms);

   always_comb begin
      mode_in          = mode_ff;
      prev_mode_in     = prev_mode_ff;
      entered_at_in    = entered_at_ff;
      last_source_in   = last_source_ff;
      battery_flag_in  = battery_flag_ff;
      cycle_start_in   = cycle_start_ff;
      connect_tries_in = connect_tries_ff;
      wake_tries_in    = wake_tries_ff;
      client_flag_in   = client_flag_ff;
      last_check_in    = last_check_ff;
      radio_sleep_in   = radio_sleep_ff;
      cpu_fast_in      = cpu_fast_ff;
      owns_link_in     = owns_link_ff;
      do_enter  = 1'b0;
      target    = bpms_pkg::MODE_AC;
      p_led     = 1'b0;
      p_link    = 1'b0;
      p_crit    = 1'b0;
      p_changed = 1'b0;
      p_ignored = 1'b0;

      case (bpms_pkg::action_type'(item.action))
         bpms_pkg::ACT_TICK: begin
            if (battery_flag_ff && (item.battery_level < cfg.critical_level)) begin
               radio_sleep_in = 1'b1;
               cpu_fast_in    = 1'b0;
               p_led          = 1'b1;
               p_crit         = 1'b1;
            end else begin
               case (mode_ff)
                  bpms_pkg::MODE_AC: begin
                     radio_sleep_in = 1'b0;
                     cpu_fast_in    = 1'b1;
                  end
                  bpms_pkg::MODE_BATT_ACTIVE: begin
                     radio_sleep_in = 1'b0;
                     cpu_fast_in    = 1'b1;
                     p_led          = 1'b1;
                     if (!client_flag_ff) begin
                        do_enter = 1'b1;
                        target   = bpms_pkg::MODE_CONNECTING;
                     end
                  end
                  bpms_pkg::MODE_BATT_SLEEP: begin
                     if (el_cycle < CMP_W'(cfg.sleep_ms)) begin
                        radio_sleep_in = 1'b1;
                        cpu_fast_in    = 1'b0;
                        p_led          = 1'b1;
                     end else if (el_cycle < sleep_end) begin
                        radio_sleep_in = 1'b0;
                        cpu_fast_in    = 1'b1;
                        if (!item.wifi_connected) begin
                           if (wake_tries_ff < cfg.max_attempts) begin
                              p_link        = 1'b1;
                              wake_tries_in = wake_tries_ff + 4'd1;
                           end
                        end else begin
                           do_enter = 1'b1;
                           target   = bpms_pkg::MODE_CONNECTING;
                        end
                     end else begin
                        cycle_start_in = now_t;
                     end
                  end
                  default: begin
                     if (el_entered < CMP_W'(cfg.try_window_ms)) begin
                        if (!item.wifi_connected && (connect_tries_ff < cfg.max_attempts)) begin
                           p_link           = 1'b1;
                           connect_tries_in = connect_tries_ff + 4'd1;
                        end
                     end else if (el_entered < CMP_W'(cfg.wait_end_ms)) begin
                        if (client_flag_ff) begin
                           do_enter = 1'b1;
                           target   = bpms_pkg::MODE_BATT_ACTIVE;
                        end
                     end else begin
                        do_enter = 1'b1;
                        target   = bpms_pkg::MODE_BATT_SLEEP;
                     end
                  end
               endcase
            end
         end
         bpms_pkg::ACT_SOURCE: begin
            if (el_source < CMP_W'(cfg.debounce_ms)) begin
               p_ignored = 1'b1;
            end else begin
               last_source_in  = now_t;
               battery_flag_in = item.on_battery_now;
               do_enter        = 1'b1;
               target          = item.on_battery_now ? bpms_pkg::MODE_CONNECTING
                                                     : bpms_pkg::MODE_AC;
            end
         end
         bpms_pkg::ACT_CHECK: begin
            if (el_check > CMP_W'(cfg.check_period_ms)) begin
               if (item.client_present != client_flag_ff) begin
                  client_flag_in = item.client_present;
                  if (item.client_present) begin
                     if ((mode_ff == bpms_pkg::MODE_BATT_SLEEP) ||
                         (mode_ff == bpms_pkg::MODE_CONNECTING)) begin
                        do_enter = 1'b1;
                        target   = bpms_pkg::MODE_BATT_ACTIVE;
                     end
                  end else if (mode_ff == bpms_pkg::MODE_BATT_ACTIVE) begin
                     do_enter = 1'b1;
                     target   = bpms_pkg::MODE_CONNECTING;
                  end
               end
               last_check_in = now_t;
            end
         end
         default: begin
         end
      endcase

      // Every mode entry, including re-entry of the same mode, restarts the entry and
      // sleep cycle timers and the attempt counters.
      if (do_enter) begin
         prev_mode_in     = mode_ff;
         mode_in          = target;
         entered_at_in    = now_t;
         cycle_start_in   = now_t;
         connect_tries_in = 4'd0;
         wake_tries_in    = 4'd0;
         radio_sleep_in   = (target == bpms_pkg::MODE_BATT_SLEEP);
         cpu_fast_in      = (target != bpms_pkg::MODE_BATT_SLEEP);
         owns_link_in     = (target != bpms_pkg::MODE_AC);
         if (target == bpms_pkg::MODE_BATT_ACTIVE) begin
            p_led = 1'b1;
         end
         p_changed = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff          <= bpms_pkg::MODE_AC;
         prev_mode_ff     <= bpms_pkg::MODE_AC;
         entered_at_ff    <= '0;
         last_source_ff   <= '0;
         battery_flag_ff  <= 1'b0;
         cycle_start_ff   <= '0;
         connect_tries_ff <= 4'd0;
         wake_tries_ff    <= 4'd0;
         client_flag_ff   <= 1'b0;
         last_check_ff    <= '0;
         radio_sleep_ff   <= 1'b0;
         cpu_fast_ff      <= 1'b1;
         owns_link_ff     <= 1'b0;
      end else if (advance) begin
         mode_ff          <= mode_in;
         prev_mode_ff     <= prev_mode_in;
         entered_at_ff    <= entered_at_in;
         last_source_ff   <= last_source_in;
         battery_flag_ff  <= battery_flag_in;
         cycle_start_ff   <= cycle_start_in;
         connect_tries_ff <= connect_tries_in;
         wake_tries_ff    <= wake_tries_in;
         client_flag_ff   <= client_flag_in;
         last_check_ff    <= last_check_in;
         radio_sleep_ff   <= radio_sleep_in;
         cpu_fast_ff      <= cpu_fast_in;
         owns_link_ff     <= owns_link_in;
      end
   end

   always_comb begin
      result.power_mode        = mode_in;
      result.prior_mode        = prev_mode_in;
      result.radio_sleep       = radio_sleep_in;
      result.cpu_fast          = cpu_fast_in;
      result.pm_owns_link      = owns_link_in;
      result.led_clear         = p_led;
      result.link_begin        = p_link;
      result.critical_override = p_crit;
      result.mode_changed      = p_changed;
      result.change_ignored    = p_ignored;
   end

endmodule

// ===== src/bpms_checker.sv =====
// Port-level checker for the battery power mode sequencer and its bind.
module bpms_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_power_mode,
   input logic       rsp_radio_sleep,
   input logic       rsp_cpu_fast,
   input logic       rsp_pm_owns_link,
   input logic       rsp_led_clear,
   input logic       rsp_critical_override,
   input logic       rsp_mode_changed,
   input logic       rsp_change_ignored
);

   // A result transaction is held until the consumer takes it.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result transaction dropped before it was taken");

   // A critical battery forces low power and never comes with a transition.
   a_critical_levels: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_critical_override |->
         rsp_radio_sleep && !rsp_cpu_fast && rsp_led_clear && !rsp_mode_changed)
      else $error("critical override without low-power levels");

   // A debounced source change must not move the mode.
   a_ignored_no_change: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_change_ignored |-> !rsp_mode_changed && !rsp_critical_override)
      else $error("ignored source change still changed the mode");

   // Entry into sleep sets the sleep levels.
   a_sleep_entry: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mode_changed && (rsp_power_mode == bpms_pkg::MODE_BATT_SLEEP) |->
         rsp_radio_sleep && !rsp_cpu_fast && rsp_pm_owns_link)
      else $error("sleep mode entered with wrong levels");

   // The link belongs to the monitor in AC mode after an entry.
   a_ac_entry: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mode_changed && (rsp_power_mode == bpms_pkg::MODE_AC) |->
         !rsp_pm_owns_link && rsp_cpu_fast && !rsp_radio_sleep)
      else $error("AC mode entered with wrong levels");

endmodule

bind battery_power_mode_sequencer bpms_checker u_bpms_checker (
   .clock                 (clock),
   .reset                 (reset),
   .rsp_valid             (rsp_valid),
   .rsp_ready             (rsp_ready),
   .rsp_power_mode        (rsp_power_mode),
   .rsp_radio_sleep       (rsp_radio_sleep),
   .rsp_cpu_fast          (rsp_cpu_fast),
   .rsp_pm_owns_link      (rsp_pm_owns_link),
   .rsp_led_clear         (rsp_led_clear),
   .rsp_critical_override (rsp_critical_override),
   .rsp_mode_changed      (rsp_mode_changed),
   .rsp_change_ignored    (rsp_change_ignored)
);

// ===== dv/tb.sv =====
// Self-checking testbench for the battery power mode sequencer with a built-in mode predictor.
`timescale 1ns / 100ps

module tb;

   localparam int CYCLE_LIMIT = 200000;
   localparam int REPORT_LIMIT = 10;
   localparam int HOLD_OFF_CYCLES = 300;

   logic                             clock;
   logic                             reset;
   logic                             req_valid;
   logic                             req_ready;
   logic [1:0]                       req_action;
   logic [bpms_pkg::NOW_W-1:0]       req_now_ms;
   logic                             req_on_battery_now;
   logic                             req_wifi_connected;
   logic                             req_client_present;
   logic [6:0]                       req_battery_level;
   logic                             rsp_valid;
   logic                             rsp_ready;
   logic [1:0]                       rsp_power_mode;
   logic [1:0]                       rsp_prior_mode;
   logic                             rsp_radio_sleep;
   logic                             rsp_cpu_fast;
   logic                             rsp_pm_owns_link;
   logic                             rsp_led_clear;
   logic                             rsp_link_begin;
   logic                             rsp_critical_override;
   logic                             rsp_mode_changed;
   logic                             rsp_change_ignored;
   logic                             csr_write;
   logic [bpms_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [bpms_pkg::CSR_DATA_W-1:0]  csr_wdata;

   // Predictor state: a shadow of the register file and of the mode logic.
   bpms_pkg::cfg_type  cfg_shadow;
   bpms_pkg::mode_type cur_mode;
   bpms_pkg::mode_type last_mode;
   logic [31:0]        entered_at;
   logic [31:0]        last_source_at;
   logic [31:0]        cycle_start;
   logic [31:0]        last_check_at;
   logic               on_battery;
   logic               client_seen;
   logic [3:0]         connect_tries;
   logic [3:0]         wake_tries;
   logic               lvl_radio_sleep;
   logic               lvl_cpu_fast;
   logic               lvl_owns_link;

   bpms_pkg::rsp_type  expected_status[$];
   int unsigned        mismatch_count;
   int unsigned        cycle_count;
   int unsigned        hold_off_len;
   bit                 idling_on;
   logic [31:0]        stamp_ms;

   battery_power_mode_sequencer u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_action            (req_action),
      .req_now_ms            (req_now_ms),
      .req_on_battery_now    (req_on_battery_now),
      .req_wifi_connected    (req_wifi_connected),
      .req_client_present    (req_client_present),
      .req_battery_level     (req_battery_level),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_power_mode        (rsp_power_mode),
      .rsp_prior_mode        (rsp_prior_mode),
      .rsp_radio_sleep       (rsp_radio_sleep),
      .rsp_cpu_fast          (rsp_cpu_fast),
      .rsp_pm_owns_link      (rsp_pm_owns_link),
      .rsp_led_clear         (rsp_led_clear),
      .rsp_link_begin        (rsp_link_begin),
      .rsp_critical_override (rsp_critical_override),
      .rsp_mode_changed      (rsp_mode_changed),
      .rsp_change_ignored    (rsp_change_ignored),
      .csr_write             (csr_write),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d transactions outstanding", cycle_count,
                  expected_status.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic void reset_predictor();
      cfg_shadow.debounce_ms     = bpms_pkg::DEBOUNCE_RST;
      cfg_shadow.sleep_ms        = bpms_pkg::SLEEP_RST;
      cfg_shadow.awake_ms        = bpms_pkg::AWAKE_RST;
      cfg_shadow.critical_level  = bpms_pkg::CRITICAL_RST;
      cfg_shadow.try_window_ms   = bpms_pkg::TRY_WINDOW_RST;
      cfg_shadow.wait_end_ms     = bpms_pkg::WAIT_END_RST;
      cfg_shadow.check_period_ms = bpms_pkg::CHECK_PERIOD_RST;
      cfg_shadow.max_attempts    = bpms_pkg::MAX_ATTEMPTS_RST;
      cur_mode        = bpms_pkg::MODE_AC;
      last_mode       = bpms_pkg::MODE_AC;
      entered_at      = '0;
      last_source_at  = '0;
      cycle_start     = '0;
      last_check_at   = '0;
      on_battery      = 1'b0;
      client_seen     = 1'b0;
      connect_tries   = '0;
      wake_tries      = '0;
      lvl_radio_sleep = 1'b0;
      lvl_cpu_fast    = 1'b1;
      lvl_owns_link   = 1'b0;
   endfunction

   // Every transition, including one into the current mode, restarts the entry and cycle
   // timers and the attempt counters.
   function automatic void enter_mode(input bpms_pkg::mode_type target,
                                      input logic [31:0] now,
                                      inout bpms_pkg::rsp_type res);
      last_mode       = cur_mode;
      cur_mode        = target;
      entered_at      = now;
      cycle_start     = now;
      connect_tries   = '0;
      wake_tries      = '0;
      lvl_radio_sleep = (target == bpms_pkg::MODE_BATT_SLEEP);
      lvl_cpu_fast    = (target != bpms_pkg::MODE_BATT_SLEEP);
      lvl_owns_link   = (target != bpms_pkg::MODE_AC);
      if (target == bpms_pkg::MODE_BATT_ACTIVE)
         res.led_clear = 1'b1;
      res.mode_changed = 1'b1;
   endfunction

   function automatic bpms_pkg::rsp_type predict_mode_step(input bpms_pkg::req_type r);
      bpms_pkg::rsp_type res;
      logic [31:0]       elapsed;
      logic [20:0]       cycle_len;
      res = '0;
      cycle_len = {1'b0, cfg_shadow.sleep_ms} + {1'b0, cfg_shadow.awake_ms};
      case (r.action)
         bpms_pkg::ACT_TICK: begin
            if (on_battery && r.battery_level < cfg_shadow.critical_level) begin
               lvl_radio_sleep = 1'b1;
               lvl_cpu_fast = 1'b0;
               res.led_clear = 1'b1;
               res.critical_override = 1'b1;
            end else begin
               case (cur_mode)
                  bpms_pkg::MODE_AC: begin
                     lvl_radio_sleep = 1'b0;
                     lvl_cpu_fast = 1'b1;
                  end
                  bpms_pkg::MODE_BATT_ACTIVE: begin
                     lvl_radio_sleep = 1'b0;
                     lvl_cpu_fast = 1'b1;
                     res.led_clear = 1'b1;
                     if (!client_seen)
                        enter_mode(bpms_pkg::MODE_CONNECTING, r.now_ms, res);
                  end
                  bpms_pkg::MODE_BATT_SLEEP: begin
                     elapsed = r.now_ms - cycle_start;
                     if (elapsed < {12'd0, cfg_shadow.sleep_ms}) begin
                        lvl_radio_sleep = 1'b1;
                        lvl_cpu_fast = 1'b0;
                        res.led_clear = 1'b1;
                     end else if (elapsed < {11'd0, cycle_len}) begin
                        lvl_radio_sleep = 1'b0;
                        lvl_cpu_fast = 1'b1;
                        if (r.wifi_connected) begin
                           enter_mode(bpms_pkg::MODE_CONNECTING, r.now_ms, res);
                        end else if (wake_tries < cfg_shadow.max_attempts) begin
                           res.link_begin = 1'b1;
                           wake_tries = wake_tries + 4'd1;
                        end
                     end else begin
                        // The cycle restarts but the wake attempt count carries over.
                        cycle_start = r.now_ms;
                     end
                  end
                  default: begin
                     elapsed = r.now_ms - entered_at;
                     if (elapsed < {12'd0, cfg_shadow.try_window_ms}) begin
                        if (!r.wifi_connected && connect_tries < cfg_shadow.max_attempts) begin
                           res.link_begin = 1'b1;
                           connect_tries = connect_tries + 4'd1;
                        end
                     end else if (elapsed < {12'd0, cfg_shadow.wait_end_ms}) begin
                        if (client_seen)
                           enter_mode(bpms_pkg::MODE_BATT_ACTIVE, r.now_ms, res);
                     end else begin
                        enter_mode(bpms_pkg::MODE_BATT_SLEEP, r.now_ms, res);
                     end
                  end
               endcase
            end
         end
         bpms_pkg::ACT_SOURCE: begin
            if (r.now_ms - last_source_at < {16'd0, cfg_shadow.debounce_ms}) begin
               res.change_ignored = 1'b1;
            end else begin
               last_source_at = r.now_ms;
               on_battery = r.on_battery_now;
               enter_mode(r.on_battery_now ? bpms_pkg::MODE_CONNECTING : bpms_pkg::MODE_AC,
                          r.now_ms, res);
            end
         end
         bpms_pkg::ACT_CHECK: begin
            if (r.now_ms - last_check_at > {16'd0, cfg_shadow.check_period_ms}) begin
               if (r.client_present != client_seen) begin
                  client_seen = r.client_present;
                  if (r.client_present) begin
                     if (cur_mode == bpms_pkg::MODE_BATT_SLEEP ||
                         cur_mode == bpms_pkg::MODE_CONNECTING)
                        enter_mode(bpms_pkg::MODE_BATT_ACTIVE, r.now_ms, res);
                  end else if (cur_mode == bpms_pkg::MODE_BATT_ACTIVE) begin
                     enter_mode(bpms_pkg::MODE_CONNECTING, r.now_ms, res);
                  end
               end
               last_check_at = r.now_ms;
            end
         end
         default: ;
      endcase
      res.power_mode   = cur_mode;
      res.prior_mode   = last_mode;
      res.radio_sleep  = lvl_radio_sleep;
      res.cpu_fast     = lvl_cpu_fast;
      res.pm_owns_link = lvl_owns_link;
      return res;
   endfunction

   task automatic send_request(input bpms_pkg::action_type act, input logic [31:0] now,
                               input bit on_batt, input bit wifi, input bit present,
                               input logic [6:0] level);
      bpms_pkg::req_type item;
      int unsigned       gap;
      item.action         = act;
      item.now_ms         = now;
      item.on_battery_now = on_batt;
      item.wifi_connected = wifi;
      item.client_present = present;
      item.battery_level  = level;
      if (idling_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 8);
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid          = 1'b1;
      req_action         = item.action;
      req_now_ms         = item.now_ms;
      req_on_battery_now = item.on_battery_now;
      req_wifi_connected = item.wifi_connected;
      req_client_present = item.client_present;
      req_battery_level  = item.battery_level;
      do @(posedge clock); while (!req_ready);
      expected_status.push_back(predict_mode_step(item));
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_status.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_register(input bpms_pkg::csr_index_type idx,
                                 input logic [bpms_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_write = 1'b1;
      csr_index = idx;
      csr_wdata = value;
   endtask

   // Registers change only with the block idle, so the shadow is updated in one go.
   task automatic apply_settings(input bpms_pkg::cfg_type s);
      drain_results();
      write_register(bpms_pkg::CSR_DEBOUNCE, {4'd0, s.debounce_ms});
      write_register(bpms_pkg::CSR_SLEEP, s.sleep_ms);
      write_register(bpms_pkg::CSR_AWAKE, s.awake_ms);
      write_register(bpms_pkg::CSR_CRITICAL, {13'd0, s.critical_level});
      write_register(bpms_pkg::CSR_TRY_WINDOW, s.try_window_ms);
      write_register(bpms_pkg::CSR_WAIT_END, s.wait_end_ms);
      write_register(bpms_pkg::CSR_CHECK_PERIOD, {4'd0, s.check_period_ms});
      write_register(bpms_pkg::CSR_MAX_ATTEMPTS, {16'd0, s.max_attempts});
      @(negedge clock);
      csr_write = 1'b0;
      cfg_shadow = s;
   endtask

   function automatic bpms_pkg::cfg_type short_timings();
      bpms_pkg::cfg_type s;
      s.debounce_ms     = 16'd50;
      s.sleep_ms        = 20'd400;
      s.awake_ms        = 20'd200;
      s.critical_level  = 7'd10;
      s.try_window_ms   = 20'd150;
      s.wait_end_ms     = 20'd400;
      s.check_period_ms = 16'd30;
      s.max_attempts    = 4'd3;
      return s;
   endfunction

   function automatic bpms_pkg::cfg_type random_timings();
      bpms_pkg::cfg_type s;
      s.debounce_ms     = 16'($urandom_range(0, 200));
      s.sleep_ms        = 20'($urandom_range(0, 600));
      s.awake_ms        = 20'($urandom_range(0, 400));
      s.critical_level  = 7'($urandom_range(0, 127));
      s.try_window_ms   = 20'($urandom_range(0, 300));
      s.wait_end_ms     = 20'($urandom_range(0, 800));
      s.check_period_ms = 16'($urandom_range(0, 100));
      s.max_attempts    = 4'($urandom_range(0, 15));
      return s;
   endfunction

   // Mostly ticks and client checks on a forward-running clock, with source changes
   // mixed in; a few items jump the timestamp anywhere or move it backwards.
   task automatic run_traffic(input int unsigned count, input int unsigned step_max);
      int unsigned          pick;
      bpms_pkg::action_type act;
      logic [6:0]           level;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 55)
            act = bpms_pkg::ACT_TICK;
         else if (pick < 70)
            act = bpms_pkg::ACT_SOURCE;
         else if (pick < 95)
            act = bpms_pkg::ACT_CHECK;
         else
            act = bpms_pkg::ACT_NONE;
         pick = $urandom_range(0, 99);
         if (pick < 2)
            stamp_ms = $urandom();
         else if (pick < 4)
            stamp_ms = stamp_ms - $urandom_range(0, step_max);
         else
            stamp_ms = stamp_ms + $urandom_range(0, step_max);
         pick = $urandom_range(0, 99);
         if (pick < 12)
            level = 7'($urandom_range(0, 15));
         else if (pick < 17)
            level = 7'($urandom_range(0, 127));
         else
            level = 7'($urandom_range(20, 100));
         send_request(act, stamp_ms, $urandom_range(0, 99) < 80, 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), level);
      end
   endtask

   // Walks the default timings through every mode, the attempt limit, a critical
   // battery tick, a debounced change and the unused action code.
   task automatic test_reset_sequence();
      send_request(bpms_pkg::ACT_TICK, 32'd0, 1'b0, 1'b0, 1'b0, 7'd100);
      send_request(bpms_pkg::ACT_SOURCE, 32'd1000, 1'b1, 1'b0, 1'b0, 7'd100);
      send_request(bpms_pkg::ACT_SOURCE, 32'd3000, 1'b1, 1'b0, 1'b0, 7'd100);
      send_request(bpms_pkg::ACT_TICK, 32'd3100, 1'b0, 1'b0, 1'b0, 7'd100);
      send_request(bpms_pkg::ACT_TICK, 32'd3200, 1'b0, 1'b0, 1'b0, 7'd100);
      send_request(bpms_pkg::ACT_TICK, 32'd3300, 1'b0, 1'b0, 1'b0, 7'd100);
      send_request(bpms_pkg::ACT_TICK, 32'd3400, 1'b0, 1'b0, 1'b0, 7'd100);
      send_request(bpms_pkg::ACT_CHECK, 32'd5001, 1'b0, 1'b0, 1'b1, 7'd100);
      send_request(bpms_pkg::ACT_TICK, 32'd5100, 1'b0, 1'b0, 1'b0, 7'd5);
      send_request(bpms_pkg::ACT_TICK, 32'd5200, 1'b0, 1'b0, 1'b0, 7'd100);
      send_request(bpms_pkg::ACT_CHECK, 32'd10200, 1'b0, 1'b0, 1'b0, 7'd100);
      send_request(bpms_pkg::ACT_TICK, 32'd60000, 1'b0, 1'b0, 1'b0, 7'd100);
      send_request(bpms_pkg::ACT_TICK, 32'd60100, 1'b0, 1'b0, 1'b0, 7'd100);
      send_request(bpms_pkg::ACT_TICK, 32'd120100, 1'b0, 1'b0, 1'b0, 7'd100);
      send_request(bpms_pkg::ACT_TICK, 32'd120200, 1'b0, 1'b1, 1'b0, 7'd100);
      send_request(bpms_pkg::ACT_NONE, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 7'd127);
      send_request(bpms_pkg::ACT_SOURCE, 32'd130000, 1'b0, 1'b0, 1'b0, 7'd100);
      send_request(bpms_pkg::ACT_SOURCE, 32'd140000, 1'b1, 1'b0, 1'b0, 7'd100);
      send_request(bpms_pkg::ACT_SOURCE, 32'd150000, 1'b1, 1'b0, 1'b0, 7'd100);
   endtask

   task automatic test_timestamp_wrap();
      send_request(bpms_pkg::ACT_SOURCE, 32'hFFFF_F000, 1'b1, 1'b0, 1'b0, 7'd127);
      send_request(bpms_pkg::ACT_TICK, 32'hFFFF_FF00, 1'b0, 1'b0, 1'b0, 7'd127);
      send_request(bpms_pkg::ACT_TICK, 32'h0000_0800, 1'b0, 1'b0, 1'b0, 7'd127);
      send_request(bpms_pkg::ACT_TICK, 32'h0000_3000, 1'b0, 1'b0, 1'b0, 7'd127);
   endtask

   task automatic test_register_extremes();
      bpms_pkg::cfg_type s;
      s = '0;
      apply_settings(s);
      send_request(bpms_pkg::ACT_SOURCE, 32'h0001_0000, 1'b1, 1'b0, 1'b0, 7'd0);
      send_request(bpms_pkg::ACT_TICK, 32'h0001_0000, 1'b0, 1'b0, 1'b0, 7'd0);
      send_request(bpms_pkg::ACT_TICK, 32'h0001_0000, 1'b0, 1'b0, 1'b0, 7'd0);
      s.debounce_ms     = 16'hFFFF;
      s.sleep_ms        = 20'hFFFFF;
      s.awake_ms        = 20'hFFFFF;
      s.critical_level  = 7'h7F;
      s.try_window_ms   = 20'hFFFFF;
      s.wait_end_ms     = 20'hFFFFF;
      s.check_period_ms = 16'hFFFF;
      s.max_attempts    = 4'hF;
      apply_settings(s);
      send_request(bpms_pkg::ACT_SOURCE, 32'h8000_0000, 1'b1, 1'b0, 1'b0, 7'd100);
      send_request(bpms_pkg::ACT_TICK, 32'h8000_0001, 1'b0, 1'b0, 1'b0, 7'd126);
      send_request(bpms_pkg::ACT_TICK, 32'h8000_0002, 1'b0, 1'b0, 1'b0, 7'd127);
   endtask

   task automatic test_random_traffic();
      bpms_pkg::cfg_type s;
      apply_settings(short_timings());
      stamp_ms = $urandom();
      run_traffic(200, 60);
      apply_settings(random_timings());
      stamp_ms = 32'hFFFF_FFFF - $urandom_range(0, 2000);
      run_traffic(150, 80);
      apply_settings(random_timings());
      run_traffic(150, 80);
      s = '0;
      apply_settings(s);
      run_traffic(100, 20);
      s.debounce_ms     = 16'hFFFF;
      s.sleep_ms        = 20'hFFFFF;
      s.awake_ms        = 20'hFFFFF;
      s.critical_level  = 7'h7F;
      s.try_window_ms   = 20'hFFFFF;
      s.wait_end_ms     = 20'hFFFFF;
      s.check_period_ms = 16'hFFFF;
      s.max_attempts    = 4'hF;
      apply_settings(s);
      run_traffic(100, 400000);
      s.debounce_ms     = bpms_pkg::DEBOUNCE_RST;
      s.sleep_ms        = bpms_pkg::SLEEP_RST;
      s.awake_ms        = bpms_pkg::AWAKE_RST;
      s.critical_level  = bpms_pkg::CRITICAL_RST;
      s.try_window_ms   = bpms_pkg::TRY_WINDOW_RST;
      s.wait_end_ms     = bpms_pkg::WAIT_END_RST;
      s.check_period_ms = bpms_pkg::CHECK_PERIOD_RST;
      s.max_attempts    = bpms_pkg::MAX_ATTEMPTS_RST;
      apply_settings(s);
      run_traffic(150, 5000);
   endtask

   // The receiver stops for a long stretch while requests keep coming, so the
   // pipeline fills and req_ready must drop.
   task automatic test_backpressure();
      apply_settings(short_timings());
      hold_off_len = HOLD_OFF_CYCLES;
      run_traffic(200, 60);
   endtask

   task automatic test_steady_stream();
      apply_settings(random_timings());
      idling_on = 1'b0;
      run_traffic(200, 60);
   endtask

   initial begin : sequence_tests
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_action         = bpms_pkg::ACT_TICK;
      req_now_ms         = '0;
      req_on_battery_now = 1'b0;
      req_wifi_connected = 1'b0;
      req_client_present = 1'b0;
      req_battery_level  = '0;
      csr_write          = 1'b0;
      csr_index          = bpms_pkg::CSR_DEBOUNCE;
      csr_wdata          = '0;
      mismatch_count     = 0;
      cycle_count        = 0;
      hold_off_len       = 0;
      idling_on          = 1'b1;
      stamp_ms           = '0;
      reset_predictor();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_reset_sequence();
      test_timestamp_wrap();
      test_register_extremes();
      test_random_traffic();
      test_backpressure();
      test_steady_stream();
      drain_results();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && expected_status.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin : drive_rsp_ready
      int unsigned stall;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_len > 0) begin
            stall = hold_off_len;
            hold_off_len = 0;
            rsp_ready = 1'b0;
            repeat (stall - 1) @(negedge clock);
         end else if (idling_on && $urandom_range(0, 5) == 0) begin
            rsp_ready = 1'b0;
            repeat ($urandom_range(1, 8) - 1) @(negedge clock);
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   task automatic compare_field(input string field, input int want, input int got);
      if (want != got) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("Mismatch on %s at %0t: expected %0d, actual %0d", field, $time, want, got);
      end
   endtask

   always @(posedge clock) begin : check_results
      bpms_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_status.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("Unexpected transaction at %0t: expected none, actual mode %0d",
                        $time, rsp_power_mode);
         end else begin
            want = expected_status.pop_front();
            compare_field("power_mode", int'(want.power_mode), int'(rsp_power_mode));
            compare_field("prior_mode", int'(want.prior_mode), int'(rsp_prior_mode));
            compare_field("radio_sleep", int'(want.radio_sleep), int'(rsp_radio_sleep));
            compare_field("cpu_fast", int'(want.cpu_fast), int'(rsp_cpu_fast));
            compare_field("pm_owns_link", int'(want.pm_owns_link), int'(rsp_pm_owns_link));
            compare_field("led_clear", int'(want.led_clear), int'(rsp_led_clear));
            compare_field("link_begin", int'(want.link_begin), int'(rsp_link_begin));
            compare_field("critical_override", int'(want.critical_override),
                          int'(rsp_critical_override));
            compare_field("mode_changed", int'(want.mode_changed), int'(rsp_mode_changed));
            compare_field("change_ignored", int'(want.change_ignored),
                          int'(rsp_change_ignored));
         end
      end
   end

endmodule
